// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when pre holds, post must hold in the same cycle
`define ASSERT_IMPLIES(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, letter codes and small helpers shared by the Playfair encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int GRID_SIDE   = 5;
    localparam int CELLS       = GRID_SIDE * GRID_SIDE;
    localparam int ALPHA       = 26;
    localparam int LETTER_W    = 5;
    localparam int RC_W        = $clog2(GRID_SIDE);
    localparam int QUEUE_DEPTH = 2;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [RC_W-1:0]     rc_t;

    localparam letter_t CODE_I = letter_t'(8);
    localparam letter_t CODE_J = letter_t'(9);
    localparam letter_t CODE_X = letter_t'(23);

    typedef enum logic
    {
        CMD_KEY,
        CMD_PAIR
    } cmd_kind_t;

    // one unit of work for the back end: a key letter or a letter pair
    typedef struct packed
    {
        cmd_kind_t kind;
        letter_t   a;
        letter_t   b;
        logic      fin;
        logic      restart;
    } cmd_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_FILL,
        BK_LOOK,
        BK_CELL,
        BK_OUT1
    } bk_state_t;

    function automatic rc_t wrap_inc(input rc_t x);
        rc_t r;
        if (x == rc_t'(GRID_SIDE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = x + rc_t'(1);
        end
        return r;
    endfunction

    function automatic letter_t cell_index(input rc_t row, input rc_t col);
        letter_t idx;
        idx = letter_t'(row) * letter_t'(GRID_SIDE) + letter_t'(col);
        return idx;
    endfunction

endpackage

// ----- rtl/playfair_cipher_encryptor_top.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_encryptor_top
// Playfair encryptor over letter codes 0..25 with j folded into i.
// ----------------------------------------------------------------------------
// Items are taken one a cycle while the two-entry command queue has room; a
// doubled final plaintext letter holds the input until its second pair is
// pushed. The back end takes one command at a time: a key letter not yet in
// the square is placed as it is popped, the final key letter also starts the
// alphabet walk that fills the rest of the square (26 letters, one a cycle),
// and each plaintext pair goes through position lookup, cell lookup, then each
// ciphertext letter in turn into the output register, waiting on a stall.
// ----------------------------------------------------------------------------
module playfair_cipher_encryptor_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic             action,
    input  pfe_pkg::letter_t letter,
    input  logic             last,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output pfe_pkg::letter_t cipher_letter,
    output logic             last_out
);
    import pfe_pkg::*;

`include "assert_macros.svh"

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_in_cmd;
    cmd_t q_out_cmd;

    pfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .letter    (letter),
        .last      (last),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .full      (q_full)
    );

    pfe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_out_cmd),
        .empty    (q_empty)
    );

    pfe_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .cmd           (q_out_cmd),
        .pop           (q_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .cipher_letter (cipher_letter),
        .last_out      (last_out)
    );

    `ASSERT_ALWAYS(a_no_push_full, !(q_push && q_full), "command pushed into full queue")
    `ASSERT_ALWAYS(a_no_pop_empty, !(q_pop && q_empty), "command popped from empty queue")
    `ASSERT_IMPLIES(a_full_stalls, q_full, req_stall, "input open while queue is full")
    `ASSERT_IMPLIES(a_letter_range, rsp_valid, cipher_letter < letter_t'(ALPHA), "cipher letter out of range")

endmodule

// ----- rtl/pfe_front.sv -----
// ----------------------------------------------------------------------------
// pfe_front
// Accepts items, folds letters and pairs plaintext into back-end commands.
// ----------------------------------------------------------------------------
module pfe_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic            action,
    input  pfe_pkg::letter_t letter,
    input  logic            last,
    output logic            push,
    output pfe_pkg::cmd_t   push_cmd,
    input  logic            full
);
    import pfe_pkg::*;

    logic    key_done_reg, key_done_next;
    logic    held_valid_reg, held_valid_next;
    letter_t held_reg, held_next;
    logic    pend_reg, pend_next;
    letter_t pend_letter_reg, pend_letter_next;

    letter_t folded;
    letter_t plain;
    logic    accept;

    assign folded    = (letter == CODE_J) ? CODE_I : letter;
    assign plain     = (folded >= letter_t'(ALPHA)) ? CODE_X : folded;
    assign req_stall = full || pend_reg;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        key_done_next    = key_done_reg;
        held_valid_next  = held_valid_reg;
        held_next        = held_reg;
        pend_next        = pend_reg;
        pend_letter_next = pend_letter_reg;
        push             = 1'b0;
        push_cmd.kind    = CMD_PAIR;
        push_cmd.a       = plain;
        push_cmd.b       = CODE_X;
        push_cmd.fin     = last;
        push_cmd.restart = 1'b0;

        if (pend_reg)
        begin
            // second pair of a doubled final letter
            push_cmd.a = pend_letter_reg;
            push_cmd.fin = 1'b1;
            if (!full)
            begin
                push = 1'b1;
                pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (action == 1'b0)
            begin
                push             = 1'b1;
                push_cmd.kind    = CMD_KEY;
                push_cmd.a       = folded;
                push_cmd.restart = key_done_reg;
                key_done_next    = last;
                held_valid_next  = 1'b0;
            end
            else if (key_done_reg)
            begin
                if (!held_valid_reg)
                begin
                    if (last)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        held_next = plain;
                        held_valid_next = 1'b1;
                    end
                end
                else if (held_reg == plain && plain != CODE_X)
                begin
                    // doubled letter: pad with x, keep the letter for the next pair
                    push = 1'b1;
                    push_cmd.a = held_reg;
                    push_cmd.fin = 1'b0;
                    if (last)
                    begin
                        pend_next = 1'b1;
                        pend_letter_next = plain;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        held_next = plain;
                    end
                end
                else
                begin
                    push = 1'b1;
                    push_cmd.a = held_reg;
                    push_cmd.b = plain;
                    held_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_done_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            key_done_reg   <= key_done_next;
            held_valid_reg <= held_valid_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg        <= held_next;
        pend_letter_reg <= pend_letter_next;
    end

endmodule

// ----- rtl/pfe_queue.sv -----
// ----------------------------------------------------------------------------
// pfe_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pfe_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output pfe_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import pfe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/pfe_back.sv -----
// ----------------------------------------------------------------------------
// pfe_back
// Builds the key square and encrypts letter pairs into the output register.
// ----------------------------------------------------------------------------
module pfe_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  pfe_pkg::cmd_t    cmd,
    output logic             pop,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output pfe_pkg::letter_t cipher_letter,
    output logic             last_out
);
    import pfe_pkg::*;

    // square by cell, and {row, col} by letter
    letter_t           sq_mem  [CELLS];
    logic [2*RC_W-1:0] pos_mem [ALPHA];

    bk_state_t         state_reg, state_next;
    logic [ALPHA-1:0]  used_reg, used_next;
    letter_t           fill_reg, fill_next;
    rc_t               row_reg, row_next;
    rc_t               col_reg, col_next;
    letter_t           scan_reg, scan_next;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    letter_t           out_letter_reg, out_letter_next;
    logic              out_last_reg, out_last_next;

    logic [2*RC_W-1:0] pos_a_reg, pos_b_reg;
    letter_t           sq_a_reg, sq_b_reg;

    logic              restart_now;
    logic [ALPHA-1:0]  base_used;
    letter_t           base_fill;
    rc_t               base_row;
    rc_t               base_col;
    logic [31:0]       used_wide;
    letter_t           cand;
    logic              place_try;
    logic              place_en;
    logic              pos_rd_en;
    logic              sq_rd_en;
    logic              out_free;
    rc_t               r1, c1, r2, c2;
    letter_t           addr_a, addr_b;

    assign restart_now = (state_reg == BK_IDLE) && !empty && (cmd.kind == CMD_KEY)
                         && cmd.restart;
    assign base_used = restart_now ? '0 : used_reg;
    assign base_fill = restart_now ? '0 : fill_reg;
    assign base_row  = restart_now ? '0 : row_reg;
    assign base_col  = restart_now ? '0 : col_reg;
    assign used_wide = {{(32 - ALPHA){1'b0}}, base_used};
    assign cand      = (state_reg == BK_FILL) ? scan_reg : cmd.a;
    assign place_try = ((state_reg == BK_IDLE) && !empty && (cmd.kind == CMD_KEY))
                       || ((state_reg == BK_FILL) && (scan_reg != CODE_J));
    assign place_en  = place_try && (cand < letter_t'(ALPHA)) && !used_wide[cand]
                       && (base_fill < letter_t'(CELLS));
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign r1 = pos_a_reg[2*RC_W-1:RC_W];
    assign c1 = pos_a_reg[RC_W-1:0];
    assign r2 = pos_b_reg[2*RC_W-1:RC_W];
    assign c2 = pos_b_reg[RC_W-1:0];

    always_comb
    begin
        if (r1 == r2)
        begin
            addr_a = cell_index(r1, wrap_inc(c1));
            addr_b = cell_index(r2, wrap_inc(c2));
        end
        else if (c1 == c2)
        begin
            addr_a = cell_index(wrap_inc(r1), c1);
            addr_b = cell_index(wrap_inc(r2), c2);
        end
        else
        begin
            addr_a = cell_index(r1, c2);
            addr_b = cell_index(r2, c1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = base_used;
        fill_next       = base_fill;
        row_next        = base_row;
        col_next        = base_col;
        scan_next       = scan_reg;
        fin_next        = fin_reg;
        pop             = 1'b0;
        pos_rd_en       = 1'b0;
        sq_rd_en        = 1'b0;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_letter_next = out_letter_reg;
        out_last_next   = out_last_reg;

        if (place_en)
        begin
            used_next = base_used | ALPHA'(32'd1 << cand);
            fill_next = base_fill + 1'b1;
            if (base_col == rc_t'(GRID_SIDE - 1))
            begin
                col_next = '0;
                row_next = base_row + 1'b1;
            end
            else
            begin
                col_next = base_col + 1'b1;
            end
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (cmd.kind == CMD_KEY)
                    begin
                        if (cmd.fin)
                        begin
                            scan_next  = '0;
                            state_next = BK_FILL;
                        end
                    end
                    else
                    begin
                        pos_rd_en  = 1'b1;
                        fin_next   = cmd.fin;
                        state_next = BK_LOOK;
                    end
                end
            end
            BK_FILL:
            begin
                // walk the alphabet, placing every letter but j not yet in the square
                scan_next = scan_reg + 1'b1;
                if (scan_reg == letter_t'(ALPHA - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_LOOK:
            begin
                sq_rd_en   = 1'b1;
                state_next = BK_CELL;
            end
            BK_CELL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = sq_a_reg;
                    out_last_next   = 1'b0;
                    state_next      = BK_OUT1;
                end
            end
            BK_OUT1:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = sq_b_reg;
                    out_last_next   = fin_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            fill_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        fin_reg        <= fin_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            sq_mem[base_fill] <= cand;
            pos_mem[cand]     <= {base_row, base_col};
        end
        if (pos_rd_en)
        begin
            pos_a_reg <= pos_mem[cmd.a];
            pos_b_reg <= pos_mem[cmd.b];
        end
        if (sq_rd_en)
        begin
            sq_a_reg <= sq_mem[addr_a];
            sq_b_reg <= sq_mem[addr_b];
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign cipher_letter = out_letter_reg;
    assign last_out      = out_last_reg;

endmodule
